@@ rtl/assert_macros.svh @@
// Assertion macros for the slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every rising clock edge outside reset.
`define GST_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/gst_pkg.sv @@
// Shared types and constants for the growable slot table.
`default_nettype none

package gst_pkg;

    localparam int MAX_SLOTS_DEF  = 64;
    localparam int ID_BITS_DEF    = 16;
    localparam int INIT_CAP_RESET = 8;

    localparam logic [1:0] FN_PARK  = 2'd0;
    localparam logic [1:0] FN_LEAVE = 2'd1;
    localparam logic [1:0] FN_DUMP  = 2'd2;

    localparam logic [2:0] STAT_PARKED   = 3'd0;
    localparam logic [2:0] STAT_REMOVED  = 3'd1;
    localparam logic [2:0] STAT_NOTFOUND = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_DUMP     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PARK,
        ST_LEAVE,
        ST_COMPACT,
        ST_DUMP,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_SWAP,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ rtl/gst_cell.sv @@
// One slot cell of the ring: holds an id, shifts toward the head, swaps with a neighbor or clears.
`default_nettype none

module gst_cell #(
    parameter int ID_BITS = gst_pkg::ID_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire gst_pkg::t_cell_cmd i_cmd,
    input  wire                   i_pair_low,
    input  wire                   i_pair_high,
    input  wire  [ID_BITS-1:0]    i_left,
    input  wire  [ID_BITS-1:0]    i_right,
    output logic [ID_BITS-1:0]    o_val
);
    import gst_pkg::*;

    logic [ID_BITS-1:0] r_val;
    logic [ID_BITS-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            CELL_CLEAR: n_val = '0;
            CELL_SHIFT: n_val = i_right;
            CELL_SWAP: begin
                // empty slots sink toward the tail, ids keep their order
                if (i_pair_low && (r_val == '0) && (i_right != '0)) begin
                    n_val = i_right;
                end else if (i_pair_high && (i_left == '0) && (r_val != '0)) begin
                    n_val = '0;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

@@ rtl/gst_ctrl.sv @@
// Head controller: request sequencing, capacity bookkeeping and the output register.
`default_nettype none
`include "assert_macros.svh"

module gst_ctrl #(
    parameter int  MAX_SLOTS = gst_pkg::MAX_SLOTS_DEF,
    parameter int  ID_BITS   = gst_pkg::ID_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_SLOTS),
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CNT_W-1:0]      i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  [1:0]            i_func,
    input  wire  [ID_BITS-1:0]    i_id,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [2:0]            o_status,
    output logic [IDX_W-1:0]      o_slot_index,
    output logic [ID_BITS-1:0]    o_slot_id,
    output logic [CNT_W-1:0]      o_capacity_now,
    output logic [CNT_W-1:0]      o_occupied_now,
    output logic                  o_last,
    input  wire  [ID_BITS-1:0]    i_head,
    output logic [ID_BITS-1:0]    o_feed,
    output gst_pkg::t_cell_cmd    o_cmd
);
    import gst_pkg::*;

    localparam int INIT_RST = (INIT_CAP_RESET > MAX_SLOTS) ? MAX_SLOTS : INIT_CAP_RESET;
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_SLOTS);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic               r_phase, n_phase;
    logic [ID_BITS-1:0] r_id, n_id;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_hit, n_hit;
    logic               r_last_occ, n_last_occ;
    logic [CNT_W-1:0]   r_cap, n_cap;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_init, n_init;
    logic [CNT_W-1:0]   r_emit, n_emit;
    logic [2:0]         r_res_status, n_res_status;
    logic [IDX_W-1:0]   r_res_idx, n_res_idx;
    logic [ID_BITS-1:0] r_res_id, n_res_id;

    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_status, n_out_status;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;
    logic [ID_BITS-1:0] r_out_id, n_out_id;
    logic [CNT_W-1:0]   r_out_cap, n_out_cap;
    logic [CNT_W-1:0]   r_out_occ, n_out_occ;
    logic               r_out_last, n_out_last;

    logic               out_free;
    logic               pos_end;
    logic [IDX_W-1:0]   pos_next;
    logic [CNT_W-1:0]   pos_w;
    logic [CNT_W:0]     cap_dbl;
    logic [CNT_W-1:0]   grow_cap;
    logic               head_occ;
    logic               at_last;
    logic               occ_last;
    logic               wr;
    logic               match;
    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W+1:0]   cnt_x3;
    logic               shrink;
    logic [CNT_W-1:0]   cfg_clamped;
    logic               load_dump;

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        pos_end  = (r_pos == IDX_W'(MAX_SLOTS - 1));
        pos_next = pos_end ? '0 : r_pos + 1'b1;
        pos_w    = CNT_W'(r_pos);
        cap_dbl  = {r_cap, 1'b0};
        grow_cap = (cap_dbl > {1'b0, CAP_MAX}) ? CAP_MAX : cap_dbl[CNT_W-1:0];
        head_occ = (i_head != '0);
        at_last  = (pos_w == r_cap - CNT_W'(1));
        occ_last = at_last ? head_occ : r_last_occ;
        wr       = !r_found && !head_occ && (pos_w < grow_cap);
        match    = !r_found && (i_head == r_id);
        cnt_dec  = r_cnt - CNT_W'(1);
        cnt_x3   = {2'b00, cnt_dec} + {1'b0, cnt_dec, 1'b0};
        // count == capacity / 3, and the floor still allows halving
        shrink   = ({2'b00, r_cap} >= cnt_x3)
                && ({2'b00, r_cap} < cnt_x3 + (CNT_W+2)'(3))
                && (r_init <= (r_cap >> 1));
        if (i_cfg_data == '0) begin
            cfg_clamped = CNT_W'(1);
        end else if (i_cfg_data > CAP_MAX) begin
            cfg_clamped = CAP_MAX;
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_id         = r_id;
        n_found      = r_found;
        n_hit        = r_hit;
        n_last_occ   = r_last_occ;
        n_cap        = r_cap;
        n_cnt        = r_cnt;
        n_init       = r_init;
        n_emit       = r_emit;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_id     = r_res_id;
        o_feed       = i_head;
        o_cmd.op     = CELL_HOLD;
        o_cmd.phase  = r_phase;
        o_in_ready   = (r_state == ST_IDLE);
        load_dump    = 1'b0;

        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_id     = r_out_id;
        n_out_cap    = r_out_cap;
        n_out_occ    = r_out_occ;
        n_out_last   = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_id       = i_id;
                    n_pos      = '0;
                    n_phase    = 1'b0;
                    n_found    = 1'b0;
                    n_last_occ = 1'b0;
                    n_emit     = '0;
                    n_res_status = STAT_NOTFOUND;
                    n_res_idx    = '0;
                    n_res_id     = '0;
                    n_state      = ST_DONE;
                    unique case (i_func)
                        FN_PARK: begin
                            if (i_id != '0) n_state = ST_PARK;
                        end
                        FN_LEAVE: begin
                            if (i_id != '0) n_state = ST_LEAVE;
                        end
                        FN_DUMP: begin
                            n_res_status = STAT_DUMP;
                            if (r_cnt != '0) n_state = ST_DUMP;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_PARK: begin
                o_cmd.op = CELL_SHIFT;
                n_pos    = pos_next;
                if (at_last) n_last_occ = head_occ;
                if (wr) begin
                    o_feed  = r_id;
                    n_found = 1'b1;
                    n_hit   = r_pos;
                end
                if (pos_end) begin
                    if (occ_last && (r_cap < CAP_MAX)) n_cap = grow_cap;
                    n_res_id = r_id;
                    if (r_found || wr) begin
                        n_res_status = STAT_PARKED;
                        n_res_idx    = wr ? r_pos : r_hit;
                        n_cnt        = r_cnt + CNT_W'(1);
                    end else begin
                        n_res_status = STAT_FULL;
                        n_res_idx    = '0;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_LEAVE: begin
                o_cmd.op = CELL_SHIFT;
                n_pos    = pos_next;
                if (match) begin
                    o_feed  = '0;
                    n_found = 1'b1;
                    n_hit   = r_pos;
                end
                if (pos_end) begin
                    n_res_id = r_id;
                    n_state  = ST_DONE;
                    if (r_found || match) begin
                        n_res_status = STAT_REMOVED;
                        n_res_idx    = match ? r_pos : r_hit;
                        n_cnt        = cnt_dec;
                        if (shrink) begin
                            n_pos   = '0;
                            n_phase = 1'b0;
                            n_state = ST_COMPACT;
                        end
                    end else begin
                        n_res_status = STAT_NOTFOUND;
                        n_res_idx    = '0;
                    end
                end
            end
            ST_COMPACT: begin
                o_cmd.op = CELL_SWAP;
                n_phase  = !r_phase;
                n_pos    = pos_next;
                if (pos_end) begin
                    n_cap   = r_cap >> 1;
                    n_state = ST_DONE;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    o_cmd.op = CELL_SHIFT;
                    n_pos    = pos_next;
                    if (head_occ) begin
                        load_dump    = 1'b1;
                        n_emit       = r_emit + CNT_W'(1);
                        n_out_valid  = 1'b1;
                        n_out_status = STAT_DUMP;
                        n_out_idx    = r_pos;
                        n_out_id     = i_head;
                        n_out_cap    = r_cap;
                        n_out_occ    = r_cnt;
                        n_out_last   = (r_emit == cnt_dec);
                    end
                    if (pos_end) n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_idx;
                    n_out_id     = r_res_id;
                    n_out_cap    = r_cap;
                    n_out_occ    = r_cnt;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_cfg_we) begin
            n_init   = cfg_clamped;
            n_cap    = cfg_clamped;
            n_cnt    = '0;
            o_cmd.op = CELL_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_phase     <= 1'b0;
            r_cap       <= CNT_W'(INIT_RST);
            r_init      <= CNT_W'(INIT_RST);
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_cap       <= n_cap;
            r_init      <= n_init;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_found      <= n_found;
        r_hit        <= n_hit;
        r_last_occ   <= n_last_occ;
        r_emit       <= n_emit;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_id     <= n_out_id;
        r_out_cap    <= n_out_cap;
        r_out_occ    <= n_out_occ;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_index   = r_out_idx;
    assign o_slot_id      = r_out_id;
    assign o_capacity_now = r_out_cap;
    assign o_occupied_now = r_out_occ;
    assign o_last         = r_out_last;

    `GST_ASSERT_ALWAYS(a_cnt_le_cap, i_clk, i_rst_n, r_cnt <= r_cap, "count above capacity")
    `GST_ASSERT_ALWAYS(a_cap_ge_init, i_clk, i_rst_n, r_cap >= r_init, "capacity below floor")
    `GST_ASSERT_IMPLIES(a_dump_emit, i_clk, i_rst_n, load_dump, r_emit < r_cnt, "dump overrun")

endmodule

`default_nettype wire

@@ rtl/growable_slot_table_unit.sv @@
// Top level of the growable slot table: ring of slot cells and the head controller.
// Park and leave: the ring rotates past all MAX_SLOTS cells, then the result is loaded;
// a leave that halves the capacity adds an odd-even compaction pass over the ring.
// Dump: one rotation of the ring, paused whenever the output register is held full.
// Zero id, unused code or empty dump: the result is loaded directly. Result waits for a free output register.
// One request in flight, next accepted after the last result loads; sync active-low reset.
`default_nettype none

module growable_slot_table_unit #(
    parameter int  MAX_SLOTS = gst_pkg::MAX_SLOTS_DEF,
    parameter int  ID_BITS   = gst_pkg::ID_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_SLOTS),
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1),
    localparam int IN_TD_W   = ((ID_BITS + 7) / 8) * 8,
    localparam int OUT_W     = IDX_W + ID_BITS + 2 * CNT_W,
    localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CNT_W-1:0]      i_cfg_data,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [IN_TD_W-1:0]    s_axis_tdata,   // item_id
    input  wire  [1:0]            s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_TD_W-1:0]   m_axis_tdata,   // slot_index, slot_id, capacity_now, occupied_now
    output logic [2:0]            m_axis_tuser,   // status
    output logic                  m_axis_tlast
);
    import gst_pkg::*;

    t_cell_cmd          w_cmd;
    logic [ID_BITS-1:0] w_val [MAX_SLOTS];
    logic [ID_BITS-1:0] w_feed;
    logic [IDX_W-1:0]   w_slot_index;
    logic [ID_BITS-1:0] w_slot_id;
    logic [CNT_W-1:0]   w_cap_now;
    logic [CNT_W-1:0]   w_occ_now;

    gst_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_func         (s_axis_tuser),
        .i_id           (s_axis_tdata[ID_BITS-1:0]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (m_axis_tuser),
        .o_slot_index   (w_slot_index),
        .o_slot_id      (w_slot_id),
        .o_capacity_now (w_cap_now),
        .o_occupied_now (w_occ_now),
        .o_last         (m_axis_tlast),
        .i_head         (w_val[0]),
        .o_feed         (w_feed),
        .o_cmd          (w_cmd)
    );

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        logic [ID_BITS-1:0] w_left;
        logic [ID_BITS-1:0] w_right;
        logic               w_low;
        logic               w_high;

        if (g == 0) begin : g_head
            assign w_left = '0;
            assign w_high = 1'b0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
            assign w_high = (w_cmd.phase == 1'((g - 1) % 2));
        end

        if (g == MAX_SLOTS - 1) begin : g_tail
            assign w_right = w_feed;
            assign w_low   = 1'b0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
            assign w_low   = (w_cmd.phase == 1'(g % 2));
        end

        gst_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_pair_low  (w_low),
            .i_pair_high (w_high),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_val       (w_val[g])
        );
    end

    assign m_axis_tdata = OUT_TD_W'({w_occ_now, w_cap_now, w_slot_id, w_slot_index});

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for growable_slot_table_unit: directed and random requests vs. a table model.
`timescale 1ns / 1ps

module tb_top;
    import gst_pkg::*;

    localparam int SLOTS = MAX_SLOTS_DEF;
    localparam int OUT_TD_W = 40;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_idx;
        logic [15:0] slot_id;
        logic [6:0]  cap;
        logic [6:0]  occ;
        logic        is_last;
    } t_resp;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [6:0]          i_cfg_data;
    logic                s_axis_tvalid;
    wire                 s_axis_tready;
    logic [15:0]         s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    wire  [OUT_TD_W-1:0] m_axis_tdata;
    wire  [2:0]          m_axis_tuser;
    wire                 m_axis_tlast;

    growable_slot_table_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // table model
    logic [15:0] tbl_ids [SLOTS];
    int          tbl_cap;
    int          tbl_count;
    logic [6:0]  tbl_init_reg;

    t_resp awaited_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left = 0;
    int n_errors = 0;
    int n_words_in = 0;
    int n_words_out = 0;
    int n_cfg = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[growable_slot_table_unit] ERROR");
        $finish;
    end

    function automatic int floor_cap(logic [6:0] v);
        if (v == 0)
            return 1;
        if (v > SLOTS)
            return SLOTS;
        return int'(v);
    endfunction

    function automatic void load_table(logic [6:0] v);
        for (int i = 0; i < SLOTS; i++)
            tbl_ids[i] = '0;
        tbl_init_reg = v;
        tbl_cap = floor_cap(v);
        tbl_count = 0;
    endfunction

    function automatic void push_resp(logic [2:0] st, int idx, logic [15:0] id, bit lst);
        t_resp r;
        r.status   = st;
        r.slot_idx = idx[5:0];
        r.slot_id  = id;
        r.cap      = tbl_cap[6:0];
        r.occ      = tbl_count[6:0];
        r.is_last  = lst;
        awaited_q.push_back(r);
    endfunction

    // Updates the table model for one request and queues the words it should produce.
    function automatic void table_request(logic [1:0] fn, logic [15:0] id);
        int nc;
        int hit;
        int wr;
        int remaining;
        logic [15:0] moved;
        case (fn)
            FN_PARK: begin
                if (id == 0) begin
                    push_resp(STAT_NOTFOUND, 0, 16'h0, 1'b1);
                end else begin
                    if (tbl_ids[tbl_cap-1] != 0 && tbl_cap < SLOTS) begin
                        nc = tbl_cap * 2;
                        tbl_cap = (nc > SLOTS) ? SLOTS : nc;
                    end
                    hit = -1;
                    for (int i = 0; i < tbl_cap && hit < 0; i++)
                        if (tbl_ids[i] == 0)
                            hit = i;
                    if (hit >= 0) begin
                        tbl_ids[hit] = id;
                        tbl_count++;
                        push_resp(STAT_PARKED, hit, id, 1'b1);
                    end else begin
                        push_resp(STAT_FULL, 0, id, 1'b1);
                    end
                end
            end
            FN_LEAVE: begin
                if (id == 0) begin
                    push_resp(STAT_NOTFOUND, 0, 16'h0, 1'b1);
                end else begin
                    hit = -1;
                    for (int i = 0; i < tbl_cap && hit < 0; i++)
                        if (tbl_ids[i] == id)
                            hit = i;
                    if (hit >= 0) begin
                        tbl_ids[hit] = '0;
                        if (tbl_count > 0)
                            tbl_count--;
                        if (tbl_count == tbl_cap / 3 && floor_cap(tbl_init_reg) <= tbl_cap / 2) begin
                            wr = 0;
                            for (int j = 0; j < tbl_cap; j++) begin
                                if (tbl_ids[j] != 0) begin
                                    moved = tbl_ids[j];
                                    tbl_ids[j] = '0;
                                    tbl_ids[wr] = moved;
                                    wr++;
                                end
                            end
                            tbl_cap = tbl_cap / 2;
                        end
                        push_resp(STAT_REMOVED, hit, id, 1'b1);
                    end else begin
                        push_resp(STAT_NOTFOUND, 0, id, 1'b1);
                    end
                end
            end
            FN_DUMP: begin
                remaining = 0;
                for (int i = 0; i < tbl_cap; i++)
                    if (tbl_ids[i] != 0)
                        remaining++;
                if (remaining == 0) begin
                    push_resp(STAT_DUMP, 0, 16'h0, 1'b1);
                end else begin
                    for (int i = 0; i < tbl_cap; i++) begin
                        if (tbl_ids[i] != 0) begin
                            remaining--;
                            push_resp(STAT_DUMP, i, tbl_ids[i], remaining == 0);
                        end
                    end
                end
            end
            default: begin
                push_resp(STAT_NOTFOUND, 0, 16'h0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_present_id();
        logic [15:0] held[$];
        for (int i = 0; i < tbl_cap; i++)
            if (tbl_ids[i] != 0)
                held.push_back(tbl_ids[i]);
        if (held.size() == 0)
            return 16'($urandom_range(1, 65535));
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    // output side: random idling or a counted long hold-off
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_resp got;
        t_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6],
                   m_axis_tdata[28:22], m_axis_tdata[35:29], m_axis_tlast};
            n_words_out++;
            if (awaited_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected word: st=%0d idx=%0d id=%h cap=%0d occ=%0d last=%0b",
                             got.status, got.slot_idx, got.slot_id, got.cap, got.occ,
                             got.is_last);
            end else begin
                want = awaited_q.pop_front();
                if (got.status !== want.status || got.slot_idx !== want.slot_idx ||
                    got.slot_id !== want.slot_id || got.cap !== want.cap ||
                    got.occ !== want.occ || got.is_last !== want.is_last) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch exp: st=%0d idx=%0d id=%h cap=%0d occ=%0d last=%0b",
                                 want.status, want.slot_idx, want.slot_id, want.cap,
                                 want.occ, want.is_last);
                        $display("         got: st=%0d idx=%0d id=%h cap=%0d occ=%0d last=%0b",
                                 got.status, got.slot_idx, got.slot_id, got.cap, got.occ,
                                 got.is_last);
                    end
                end
            end
        end
    end

    task automatic send_word(logic [1:0] fn, logic [15:0] id);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = id;
        s_axis_tuser  = fn;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        n_words_in++;
        table_request(fn, id);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (awaited_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_init_cap(logic [6:0] v);
        wait_drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        load_table(v);
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_empty_table();
        send_word(FN_DUMP, 16'h0000);
        send_word(FN_LEAVE, 16'h1234);
        send_word(FN_PARK, 16'h0000);
        send_word(FN_LEAVE, 16'h0000);
        send_word(FN_UNUSED, 16'hA5A5);
    endtask

    task automatic test_grow_and_shrink();
        // zero maps to one slot: grows 1 -> 2 -> 4, then halves back with compaction
        write_init_cap(7'd0);
        send_word(FN_PARK, 16'hFFFF);
        send_word(FN_PARK, 16'h0001);
        send_word(FN_PARK, 16'h8000);
        send_word(FN_DUMP, 16'h0000);
        send_word(FN_LEAVE, 16'hFFFF);
        send_word(FN_LEAVE, 16'h0001);
        send_word(FN_DUMP, 16'h0000);
        send_word(FN_PARK, 16'h8000);
        send_word(FN_LEAVE, 16'h8000);
        send_word(FN_DUMP, 16'h0000);
    endtask

    task automatic test_register_extremes();
        write_init_cap(7'd127);
        send_word(FN_PARK, 16'h5555);
        send_word(FN_PARK, 16'hAAAA);
        send_word(FN_DUMP, 16'h0000);
        send_word(FN_LEAVE, 16'hAAAA);
    endtask

    task automatic test_backpressure();
        write_init_cap(7'd4);
        send_word(FN_PARK, 16'($urandom_range(1, 65535)));
        stall_left = 300;
        for (int i = 0; i < 4; i++)
            send_word(FN_PARK, 16'($urandom_range(1, 65535)));
        send_word(FN_DUMP, 16'h0000);
        send_word(FN_PARK, 16'($urandom_range(1, 65535)));
        wait_drain();
        send_word(FN_LEAVE, pick_present_id());
        send_word(FN_DUMP, 16'h0000);
    endtask

    task automatic test_fill_to_capacity();
        write_init_cap(7'd8);
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_count > 0 && $urandom_range(0, 9) == 0)
                send_word(FN_PARK, pick_present_id());
            else
                send_word(FN_PARK, 16'($urandom_range(1, 65535)));
        end
        send_word(FN_PARK, 16'($urandom_range(1, 65535)));
        send_word(FN_LEAVE, tbl_ids[17]);
        send_word(FN_PARK, 16'($urandom_range(1, 65535)));
        stall_left = 150;
        send_word(FN_DUMP, 16'h0000);
        for (int i = 0; i < 4; i++)
            send_word(FN_LEAVE, pick_present_id());
        send_word(FN_DUMP, 16'h0000);
    endtask

    task automatic test_random_mix();
        int pct;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 60 : 0;
            recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 36 : 0;
            write_init_cap(7'($urandom_range(1, 12)));
            for (int n = 0; n < 10; n++) begin
                pct = $urandom_range(0, 99);
                if (pct < 48)
                    send_word(FN_PARK, 16'($urandom_range(1, 65535)));
                else if (pct < 78)
                    send_word(FN_LEAVE, pick_present_id());
                else if (pct < 86)
                    send_word(FN_LEAVE, 16'($urandom_range(1, 65535)));
                else if (pct < 94)
                    send_word(FN_DUMP, 16'($urandom));
                else if (pct < 97)
                    send_word(2'($urandom_range(0, 1)), 16'h0000);
                else
                    send_word(FN_UNUSED, 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        load_table(7'(INIT_CAP_RESET));
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 60;
        test_empty_table();
        test_grow_and_shrink();
        test_register_extremes();
        test_backpressure();
        test_fill_to_capacity();
        test_random_mix();

        wait_drain();
        repeat (200) @(posedge i_clk);
        if (awaited_q.size() != 0)
            n_errors++;

        $display("covered %0d requests and %0d result words over %0d capacity settings;",
                 n_words_in, n_words_out, n_cfg + 1);
        $display("growth to the cap, full table, shrink with compaction, long output stalls");
        if (n_errors == 0) begin
            $display("[growable_slot_table_unit] OK");
        end else begin
            $display("[growable_slot_table_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ growable_slot_table_unit.f @@
+incdir+rtl
rtl/gst_pkg.sv
rtl/gst_cell.sv
rtl/gst_ctrl.sv
rtl/growable_slot_table_unit.sv
tb/tb_top.sv
